/* design/sbdu_pkg.sv */
// ----------------------------------------------------------------------------
// sbdu_pkg: shared types and helpers for the seven-bit dictionary unpacker
// Code and character types, the beat opcode, the lookup request struct and
// the code assembly function.
// ----------------------------------------------------------------------------
`default_nettype none

package sbdu_pkg;

  typedef logic [6:0] code_t;
  typedef logic [7:0] char_t;
  typedef logic [2:0] phase_t;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpDecode = 1'b1
  } op_e;

  localparam code_t  CodeEnd   = 7'd127;
  localparam phase_t LastPhase = 3'd6;   // seventh byte of a group

  // One pending dictionary lookup.
  typedef struct packed {
    code_t code;
    logic  last;
  } lookup_req_t;

  // Rebuild the code finished by the byte at phase p (0..6).
  function automatic code_t assemble_code(phase_t p, code_t carry, char_t b);
    logic [7:0]  mask;
    logic [13:0] hi;
    logic [7:0]  lo;
    mask = (8'd1 << p) - 8'd1;
    hi   = {7'd0, carry & mask[6:0]} << (3'd7 - p);
    lo   = b >> ({1'b0, p} + 4'd1);
    return hi[6:0] | lo[6:0];
  endfunction

endpackage

`default_nettype wire

/* design/sbdu_unpack.sv */
// ----------------------------------------------------------------------------
// sbdu_unpack: code assembly and lookup request queue
// Tracks group phase, carry bits and the stop flag, and holds the one or
// two codes of the current byte until the lookup stage takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdu_unpack (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 dec_fire_i,
  input  wire sbdu_pkg::char_t      packed_byte_i,
  input  wire logic                 issue_i,
  output logic                      req_valid_o,
  output sbdu_pkg::lookup_req_t     req_o
);
  import sbdu_pkg::*;

  phase_t phase_q, phase_d;
  code_t  carry_q, carry_d;
  logic   stopped_q, stopped_d;
  logic   job_valid_q, job_valid_d;
  logic   sel_q, sel_d;
  logic   two_q, two_d;
  code_t  code0_q, code0_d;
  code_t  code1_q, code1_d;

  phase_t p;
  code_t  first_code;
  code_t  second_code;

  always_comb begin
    p           = (phase_q > LastPhase) ? '0 : phase_q;
    first_code  = assemble_code(p, carry_q, packed_byte_i);
    second_code = packed_byte_i[6:0];

    phase_d     = phase_q;
    carry_d     = carry_q;
    stopped_d   = stopped_q;
    job_valid_d = job_valid_q;
    sel_d       = sel_q;
    two_d       = two_q;
    code0_d     = code0_q;
    code1_d     = code1_q;

    // Drain the current job.
    if (issue_i) begin
      if (!sel_q && two_q) begin
        sel_d = 1'b1;
      end else begin
        job_valid_d = 1'b0;
      end
    end

    // New decode beat; dropped once stopped.
    if (dec_fire_i && !stopped_q) begin
      job_valid_d = 1'b1;
      sel_d       = 1'b0;
      code0_d     = first_code;
      code1_d     = second_code;
      if (first_code == CodeEnd) begin
        two_d     = 1'b0;
        stopped_d = 1'b1;
      end else if (p == LastPhase) begin
        two_d     = 1'b1;
        phase_d   = '0;
        carry_d   = second_code;
        stopped_d = (second_code == CodeEnd);
      end else begin
        two_d     = 1'b0;
        phase_d   = p + 3'd1;
        carry_d   = second_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      carry_q     <= '0;
      stopped_q   <= 1'b0;
      job_valid_q <= 1'b0;
      sel_q       <= 1'b0;
      two_q       <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      carry_q     <= carry_d;
      stopped_q   <= stopped_d;
      job_valid_q <= job_valid_d;
      sel_q       <= sel_d;
      two_q       <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code0_q <= code0_d;
    code1_q <= code1_d;
  end

  assign req_valid_o = job_valid_q;
  assign req_o.code  = sel_q ? code1_q : code0_q;
  assign req_o.last  = sel_q || !two_q;

endmodule

`default_nettype wire

/* design/sbdu_lookup.sv */
// ----------------------------------------------------------------------------
// sbdu_lookup: dictionary memory and result register
// 128 x 8 dictionary with one write and one registered read per cycle;
// the read data register doubles as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbdu_lookup (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire sbdu_pkg::code_t      wr_index_i,
  input  wire sbdu_pkg::char_t      wr_value_i,
  input  wire logic                 req_valid_i,
  input  wire sbdu_pkg::lookup_req_t req_i,
  output logic                      issue_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output sbdu_pkg::char_t           out_char_o,
  output logic                      end_seen_o,
  output logic                      last_o
);
  import sbdu_pkg::*;

  char_t mem [128];

  char_t rd_q;
  logic  end_q;
  logic  last_q;
  logic  valid_q;

  assign issue_o = req_valid_i && (!valid_q || out_ready_i);

  // Read-before-write on a same-cycle collision.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_index_i] <= wr_value_i;
    end
    if (issue_o) begin
      rd_q   <= mem[req_i.code];
      end_q  <= (req_i.code == CodeEnd);
      last_q <= req_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (issue_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign out_char_o  = end_q ? '0 : rd_q;
  assign end_seen_o  = end_q;
  assign last_o      = end_q || last_q;

endmodule

`default_nettype wire

/* design/seven_bit_dictionary_unpacker.sv */
// ----------------------------------------------------------------------------
// seven_bit_dictionary_unpacker: dictionary-based 7-bit code unpacker
// Input beats either load a dictionary slot (op = 0) or bring one byte of a
// stream of 7-bit codes packed MSB-first, eight codes per seven bytes
// (op = 1). Each finished code is looked up and the character is emitted;
// code 127 ends the stream with an end beat (end_seen = 1, out_char = 0).
//
// Channels: valid/ready on input and output. last marks the final output
// beat caused by an input beat.
// Each code is registered in the unpacker, then its character in the lookup.
// Throughput: one input beat per cycle while the output is not stalled; the
// seventh byte of a group yields two characters and holds the input until
// its second lookup issues. The single read port of the dictionary sets
// this: one lookup per cycle.
// Reset: group phase, carry and stop flag clear; the dictionary keeps its
// contents and must be loaded before codes that use it arrive.
// Stall: while the receiver holds ready low the result register keeps its
// beat, one pending lookup waits, and the input side stops taking beats.
// After the end code, decode beats are taken and dropped until reset;
// load beats still write the dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_bit_dictionary_unpacker (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             op_i,
  input  wire sbdu_pkg::code_t  table_index_i,
  input  wire sbdu_pkg::char_t  table_value_i,
  input  wire sbdu_pkg::char_t  packed_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output sbdu_pkg::char_t       out_char_o,
  output logic                  end_seen_o,
  output logic                  last_o
);
  import sbdu_pkg::*;

  logic        in_fire;
  logic        dec_fire;
  logic        load_fire;
  logic        req_valid;
  lookup_req_t req;
  logic        issue;

  // Take a new beat when no job is pending or the pending job issues its
  // final lookup this cycle, so a load never overtakes an earlier decode.
  assign in_ready_o = !req_valid || (issue && req.last);
  assign in_fire    = in_valid_i && in_ready_o;
  assign dec_fire   = in_fire && (op_e'(op_i) == OpDecode);
  assign load_fire  = in_fire && (op_e'(op_i) == OpLoad);

  sbdu_unpack u_unpack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dec_fire_i   (dec_fire),
    .packed_byte_i(packed_byte_i),
    .issue_i      (issue),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  sbdu_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (load_fire),
    .wr_index_i  (table_index_i),
    .wr_value_i  (table_value_i),
    .req_valid_i (req_valid),
    .req_i       (req),
    .issue_o     (issue),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .end_seen_o  (end_seen_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
